/* rtl/lob_pkg.sv */
// ----------------------------------------------------------------------------
// lob_pkg
// shared types, codes and field layout of the limit order book table
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int ORDER_SLOTS_DEF = 64;
  localparam int PRICE_BITS_DEF  = 32;
  localparam int ID_BITS_DEF     = 32;

  localparam int FIELD_BITS = 32;
  localparam int STAMP_BITS = 32;

  localparam int IN_DATA_BITS  = 72;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 168;

  // input tdata layout
  localparam int IN_ID_LO    = 0;
  localparam int IN_BUY_BIT  = 32;
  localparam int IN_PRICE_LO = 33;
  localparam int IN_LIMIT_BIT = 65;

  // output tdata layout
  localparam int OUT_STATUS_LO    = 0;
  localparam int OUT_FBUY_BIT     = 3;
  localparam int OUT_FPRICE_LO    = 4;
  localparam int OUT_BID_V_BIT    = 36;
  localparam int OUT_BID_PRICE_LO = 37;
  localparam int OUT_BID_ID_LO    = 69;
  localparam int OUT_ASK_V_BIT    = 101;
  localparam int OUT_ASK_PRICE_LO = 102;
  localparam int OUT_ASK_ID_LO    = 134;
  localparam int OUT_EMPTY_BIT    = 166;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_FIND   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NOT_LIMIT = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP       = 3'd4
  } status_t;

endpackage

/* rtl/lob_cmp.sv */
// ----------------------------------------------------------------------------
// lob_cmp
// price-time priority compare of one slot against the running best
// ----------------------------------------------------------------------------
module lob_cmp #(
  parameter int PRICE_BITS = lob_pkg::PRICE_BITS_DEF
) (
  input  logic                            want_high,
  input  logic [PRICE_BITS-1:0]           cand_price,
  input  logic [lob_pkg::STAMP_BITS-1:0]  cand_age,
  input  logic                            best_valid,
  input  logic [PRICE_BITS-1:0]           best_price,
  input  logic [lob_pkg::STAMP_BITS-1:0]  best_age,
  output logic                            better
);

  logic price_gt;
  logic price_eq;

  always_comb begin
    price_gt = cand_price > best_price;
    price_eq = cand_price == best_price;
    if (!best_valid) begin
      better = 1'b1;
    end else if (price_eq) begin
      better = cand_age > best_age;
    end else begin
      better = want_high ? price_gt : !price_gt;
    end
  end

endmodule

/* rtl/limit_order_book_table_core.sv */
// ----------------------------------------------------------------------------
// limit_order_book_table_core
// resting order table with add, remove and find, reporting best bid and ask
// ----------------------------------------------------------------------------
// in_tready is low from the accept of an item (add, remove or find) until its
// result is registered at the output: the slot memory has one read port, and
// it is swept once for id match and free slot, then once more after the update
// for best bid and best ask, one slot per cycle through a single price-time
// compare unit. After reset a clearing pass over every slot runs before the
// first item is taken.
// ----------------------------------------------------------------------------
module limit_order_book_table_core #(
  parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_BITS  = lob_pkg::PRICE_BITS_DEF,
  parameter int ID_BITS     = lob_pkg::ID_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // order_id[31:0], is_buy[32], limit_price[64:33], is_limit[65], zero pad
  input  logic [lob_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // func[1:0]
  input  logic [lob_pkg::IN_USER_BITS-1:0]   in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[2:0], found_is_buy[3], found_price[35:4], bid_valid[36],
  // bid_top_price[68:37], bid_top_id[100:69], ask_valid[101],
  // ask_top_price[133:102], ask_top_id[165:134], book_empty[166], zero pad
  output logic [lob_pkg::OUT_DATA_BITS-1:0]  out_tdata
);

  localparam int AW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(ORDER_SLOTS - 1);
  localparam int SB = lob_pkg::STAMP_BITS;
  localparam int FB = lob_pkg::FIELD_BITS;

  typedef struct packed {
    logic                  vld;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [SB-1:0]         stamp;
    logic [ID_BITS-1:0]    id;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN1,
    S_OP,
    S_SCAN2,
    S_DONE
  } state_t;

  state_t state_r;

  slot_t mem [ORDER_SLOTS];
  slot_t rdata_r;
  logic  mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t mem_wdata;

  logic [AW-1:0] iss_r;
  logic          iss_on_r;
  logic          pv_r;
  logic [AW-1:0] pidx_r;

  lob_pkg::func_t        fn_r;
  logic [ID_BITS-1:0]    id_r;
  logic                  buy_r;
  logic [PRICE_BITS-1:0] price_r;
  logic                  limit_r;

  logic                  hit_r;
  logic [AW-1:0]         hit_idx_r;
  logic                  hit_side_r;
  logic [PRICE_BITS-1:0] hit_price_r;
  logic                  free_r;
  logic [AW-1:0]         free_idx_r;

  logic [SB-1:0] cnt_r;

  lob_pkg::status_t      status_r;
  logic                  f_buy_r;
  logic [PRICE_BITS-1:0] f_price_r;

  logic                  bid_v_r;
  logic [PRICE_BITS-1:0] bid_price_r;
  logic [SB-1:0]         bid_age_r;
  logic [ID_BITS-1:0]    bid_id_r;
  logic                  ask_v_r;
  logic [PRICE_BITS-1:0] ask_price_r;
  logic [SB-1:0]         ask_age_r;
  logic [ID_BITS-1:0]    ask_id_r;

  logic                              out_tvalid_r;
  logic [lob_pkg::OUT_DATA_BITS-1:0] out_data_r;

  lob_pkg::status_t op_status;
  logic             add_ok;
  logic             rm_ok;
  logic             find_ok;

  logic [SB-1:0]         cand_age;
  logic                  best_valid;
  logic [PRICE_BITS-1:0] best_price;
  logic [SB-1:0]         best_age;
  logic                  better;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // operation decode on the first sweep's findings
  always_comb begin
    op_status = lob_pkg::ST_OK;
    add_ok    = 1'b0;
    rm_ok     = 1'b0;
    find_ok   = 1'b0;
    unique case (fn_r)
      lob_pkg::FN_ADD: begin
        if (!limit_r) begin
          op_status = lob_pkg::ST_NOT_LIMIT;
        end else if (hit_r) begin
          op_status = lob_pkg::ST_DUP;
        end else if (!free_r) begin
          op_status = lob_pkg::ST_FULL;
        end else begin
          add_ok = 1'b1;
        end
      end
      lob_pkg::FN_REMOVE: begin
        if (hit_r) begin
          rm_ok = 1'b1;
        end else begin
          op_status = lob_pkg::ST_NOT_FOUND;
        end
      end
      lob_pkg::FN_FIND: begin
        if (hit_r) begin
          find_ok = 1'b1;
        end else begin
          op_status = lob_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        op_status = lob_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = iss_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == S_OP) begin
      if (add_ok) begin
        mem_we          = 1'b1;
        mem_waddr       = free_idx_r;
        mem_wdata.vld   = 1'b1;
        mem_wdata.side  = buy_r;
        mem_wdata.price = price_r;
        mem_wdata.stamp = cnt_r;
        mem_wdata.id    = id_r;
      end else if (rm_ok) begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[iss_r];
  end

  // shared compare unit, steered by the side of the slot under test
  always_comb begin
    cand_age   = cnt_r - rdata_r.stamp;
    best_valid = rdata_r.side ? bid_v_r : ask_v_r;
    best_price = rdata_r.side ? bid_price_r : ask_price_r;
    best_age   = rdata_r.side ? bid_age_r : ask_age_r;
  end

  lob_cmp #(
    .PRICE_BITS (PRICE_BITS)
  ) u_cmp (
    .want_high  (rdata_r.side),
    .cand_price (rdata_r.price),
    .cand_age   (cand_age),
    .best_valid (best_valid),
    .best_price (best_price),
    .best_age   (best_age),
    .better     (better)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      iss_r        <= '0;
      iss_on_r     <= 1'b0;
      pv_r         <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      pv_r   <= iss_on_r;
      pidx_r <= iss_r;
      if (state_r == S_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (iss_on_r) begin
        if (iss_r == LAST) begin
          iss_on_r <= 1'b0;
        end else begin
          iss_r <= iss_r + 1'b1;
        end
      end
      unique case (state_r)
        S_CLEAR: begin
          if (iss_r == LAST) begin
            iss_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            iss_r <= iss_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            fn_r     <= lob_pkg::func_t'(in_tuser);
            id_r     <= ID_BITS'(in_tdata[lob_pkg::IN_ID_LO +: FB]);
            buy_r    <= in_tdata[lob_pkg::IN_BUY_BIT];
            price_r  <= PRICE_BITS'(in_tdata[lob_pkg::IN_PRICE_LO +: FB]);
            limit_r  <= in_tdata[lob_pkg::IN_LIMIT_BIT];
            hit_r    <= 1'b0;
            free_r   <= 1'b0;
            iss_r    <= '0;
            iss_on_r <= 1'b1;
            state_r  <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (pv_r) begin
            if (rdata_r.vld && rdata_r.id == id_r && !hit_r) begin
              hit_r       <= 1'b1;
              hit_idx_r   <= pidx_r;
              hit_side_r  <= rdata_r.side;
              hit_price_r <= rdata_r.price;
            end
            if (!rdata_r.vld && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= pidx_r;
            end
            if (pidx_r == LAST) begin
              state_r <= S_OP;
            end
          end
        end
        S_OP: begin
          status_r  <= op_status;
          f_buy_r   <= find_ok & hit_side_r;
          f_price_r <= find_ok ? hit_price_r : '0;
          if (add_ok) begin
            cnt_r <= cnt_r + 1'b1;
          end
          bid_v_r  <= 1'b0;
          ask_v_r  <= 1'b0;
          iss_r    <= '0;
          iss_on_r <= 1'b1;
          state_r  <= S_SCAN2;
        end
        S_SCAN2: begin
          if (pv_r) begin
            if (rdata_r.vld && better) begin
              if (rdata_r.side) begin
                bid_v_r     <= 1'b1;
                bid_price_r <= rdata_r.price;
                bid_age_r   <= cand_age;
                bid_id_r    <= rdata_r.id;
              end else begin
                ask_v_r     <= 1'b1;
                ask_price_r <= rdata_r.price;
                ask_age_r   <= cand_age;
                ask_id_r    <= rdata_r.id;
              end
            end
            if (pidx_r == LAST) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_data_r   <= {1'b0,
                             !bid_v_r && !ask_v_r,
                             ask_v_r ? FB'(ask_id_r) : {FB{1'b0}},
                             ask_v_r ? FB'(ask_price_r) : {FB{1'b0}},
                             ask_v_r,
                             bid_v_r ? FB'(bid_id_r) : {FB{1'b0}},
                             bid_v_r ? FB'(bid_price_r) : {FB{1'b0}},
                             bid_v_r,
                             FB'(f_price_r),
                             f_buy_r,
                             status_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/lob_chk.sv */
// ----------------------------------------------------------------------------
// lob_chk
// port-level checks of the limit order book table, bound to the top level
// ----------------------------------------------------------------------------
module lob_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lob_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  localparam int FB = lob_pkg::FIELD_BITS;

  // busy after every accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[lob_pkg::OUT_EMPTY_BIT] ==
      (!out_tdata[lob_pkg::OUT_BID_V_BIT] && !out_tdata[lob_pkg::OUT_ASK_V_BIT]))
    else $error("book_empty disagrees with bid_valid and ask_valid");

  a_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[lob_pkg::OUT_BID_V_BIT] |->
      out_tdata[lob_pkg::OUT_BID_PRICE_LO +: 2*FB] == '0)
    else $error("bid fields not zero without a bid");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[lob_pkg::OUT_STATUS_LO +: 3] <= lob_pkg::ST_DUP)
    else $error("status code out of range");

endmodule

bind limit_order_book_table_core lob_chk u_lob_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
